FILE: design/czf_pkg.sv
// Package for the CRC-32C checksum block with a zeroed field.
// Holds the shared widths, register indexes, reset values, the config struct
// and the byte-wide CRC update function. It depends on nothing else.
package czf_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned OFS_W   = 8;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_D_W = 8;

    localparam logic [CRC_W-1:0] CRC_START = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY  = 32'h82F6_3B78;
    localparam logic [POS_W-1:0] POS_MAX   = 9'd511;

    localparam logic [OFS_W-1:0] OFS_RESET = 8'd20;
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;

    localparam logic [IDX_W-1:0] REG_ZERO_FIELD_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_FIELD_OFFSET      = 2'd1;
    localparam logic [IDX_W-1:0] REG_FIELD_LENGTH      = 2'd2;

    typedef struct packed {
        logic             zero_field_enable;
        logic [OFS_W-1:0] field_offset;
        logic [LEN_W-1:0] field_length;
    } cfg_t;

    // One reflected CRC-32C byte step: eight shift-and-conditional-XOR stages,
    // which flatten into a single XOR network.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

FILE: design/czf_crc_update.sv
// Combinational next-CRC logic for one message byte, including the field mask.
// Depends on czf_pkg for the config struct and the CRC byte function.
module czf_crc_update
(
    input  czf_pkg::cfg_t                 cfg,
    input  logic [czf_pkg::CRC_W-1:0]     crc,
    input  logic [czf_pkg::POS_W-1:0]     pos,
    input  logic [czf_pkg::BYTE_W-1:0]    data_byte,
    output logic [czf_pkg::CRC_W-1:0]     crc_next
);

    logic [czf_pkg::POS_W-1:0]  field_start;
    logic [czf_pkg::POS_W-1:0]  field_end;
    logic                       in_field;
    logic [czf_pkg::BYTE_W-1:0] fed_byte;

    // The field end reaches at most 270, which still fits the position width.
    assign field_start = {1'b0, cfg.field_offset};
    assign field_end   = field_start + {{(czf_pkg::POS_W-czf_pkg::LEN_W){1'b0}},
                                        cfg.field_length};
    assign in_field    = cfg.zero_field_enable && (pos >= field_start) && (pos < field_end);
    assign fed_byte    = in_field ? '0 : data_byte;
    assign crc_next    = czf_pkg::crc_byte(crc, fed_byte);

endmodule

FILE: design/crc32c_with_zeroed_field_top.sv
// Top level of the streaming CRC-32C checksum block with a zeroed field.
// Depends on czf_pkg and instantiates czf_crc_update.
//
// This block computes the reflected CRC-32C (Castagnoli) of a byte stream,
// one byte per input transfer, starting from all ones and delivering the
// inverted CRC as one output transfer on the byte marked with tlast. When
// zero_field_enable is set, the bytes at positions field_offset up to
// field_offset + field_length - 1 of each message are fed into the CRC as
// zeros, so a checksum stored inside the message does not disturb its own
// sum. After the last byte the running CRC and the byte position return to
// their start values, ready for the next message; the position saturates at
// 511 for long messages. The block takes one byte per clock cycle: the CRC
// register is updated by a single byte-wide XOR network per byte, and the
// checksum waits in an output register, so input transfers continue while a
// result is pending and stop only when that register is full and the
// downstream side is not ready. A result is registered in the cycle after its
// last byte is accepted. Configuration writes take effect from the next byte
// on and should be made between messages; index 3 is ignored.
module crc32c_with_zeroed_field_top
(
    input  logic                             clk,
    input  logic                             rst_n,

    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [czf_pkg::IDX_W-1:0]        cfg_index,
    input  logic [czf_pkg::CFG_D_W-1:0]      cfg_data,

    // Input stream of message bytes.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [czf_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // last_byte

    // Output stream of checksums.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [czf_pkg::CRC_W-1:0]        m_tdata    // [31:0] checksum
);

    czf_pkg::cfg_t                 cfg_reg;
    logic [czf_pkg::CRC_W-1:0]     crc_reg;
    logic [czf_pkg::CRC_W-1:0]     crc_next;
    logic [czf_pkg::POS_W-1:0]     pos_reg;
    logic                          out_valid_reg;
    logic [czf_pkg::CRC_W-1:0]     out_data_reg;
    logic                          in_xfer;

    // The output register can take a new result when it is empty or being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_field_enable <= 1'b0;
            cfg_reg.field_offset      <= czf_pkg::OFS_RESET;
            cfg_reg.field_length      <= czf_pkg::LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                czf_pkg::REG_ZERO_FIELD_ENABLE: cfg_reg.zero_field_enable <= cfg_data[0];
                czf_pkg::REG_FIELD_OFFSET:      cfg_reg.field_offset      <= cfg_data;
                czf_pkg::REG_FIELD_LENGTH:
                    cfg_reg.field_length <= cfg_data[czf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    czf_crc_update u_crc_update
    (
        .cfg       (cfg_reg),
        .crc       (crc_reg),
        .pos       (pos_reg),
        .data_byte (s_tdata),
        .crc_next  (crc_next)
    );

    // Running CRC and byte position; both restart after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= czf_pkg::CRC_START;
            pos_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (s_tlast)
            begin
                crc_reg <= czf_pkg::CRC_START;
                pos_reg <= '0;
            end
            else
            begin
                crc_reg <= crc_next;
                if (pos_reg != czf_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // Output register holding the finished checksum until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && s_tlast)
        begin
            out_data_reg <= ~crc_next;
        end
    end

endmodule
